// ===== rtl/cdcw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdcw_pkg
// Shared types, codes and calendar helper functions for the Gregorian date
// counter with weekday output.
// ----------------------------------------------------------------------------
`default_nettype none

package cdcw_pkg;

	// Field widths fixed by the interface.
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int WDAY_W  = 3;

	// Offset added to the year before the day number sum (March-based year).
	localparam int JDN_YEAR_OFS = 4800;
	localparam int YY_W         = 15;

	// Reciprocal constants for division by 100 and by 7.
	localparam int RECIP100       = 5243;
	localparam int RECIP100_SHIFT = 19;
	localparam int RECIP7         = 18725;
	localparam int RECIP7_SHIFT   = 17;
	localparam int Q100_W         = 9;
	localparam int Q7_W           = 13;

	// Operation codes of an input transaction.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_NEXT  = 2'd1,
		OP_PREV  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	// Status codes of a result transaction.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_LIMIT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// Floor division by 100 for values below 32768, by reciprocal multiply.
	function automatic logic [Q100_W-1:0] div100(input logic [YY_W-1:0] x);
		logic [31:0] p;
		begin
			p = 32'(x) * 32'(RECIP100);
			return p[RECIP100_SHIFT+Q100_W-1:RECIP100_SHIFT];
		end
	endfunction

	// Gregorian leap year test.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [Q100_W-1:0] q;
		logic [YEAR_W-1:0] rem;
		begin
			q   = div100(YY_W'(y));
			rem = y - YEAR_W'(YEAR_W'(q) * YEAR_W'(100));
			return (y[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
		end
	endfunction

	// Number of days in a month; zero for month codes that mean nothing.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [DAY_W-1:0] n;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
				4'd2:                                         n = leap ? 5'd29 : 5'd28;
				default:                                      n = 5'd0;
			endcase
			return n;
		end
	endfunction

	// (153 * mm + 2) / 5 modulo 7, indexed by calendar month.
	function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [WDAY_W-1:0] t;
		begin
			case (m)
				4'd1:    t = 3'd5;
				4'd2:    t = 3'd1;
				4'd3:    t = 3'd0;
				4'd4:    t = 3'd3;
				4'd5:    t = 3'd5;
				4'd6:    t = 3'd1;
				4'd7:    t = 3'd3;
				4'd8:    t = 3'd6;
				4'd9:    t = 3'd2;
				4'd10:   t = 3'd4;
				4'd11:   t = 3'd0;
				4'd12:   t = 3'd2;
				default: t = 3'd0;
			endcase
			return t;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_counter_weekday.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter_weekday
// Gregorian date counter with load, next day, previous day and query
// operations; every transaction returns the resulting date, weekday and status.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_ready   operation, load_day, load_month, load_year
// out      out_valid / out_ready cur_day, cur_month, cur_year, weekday, status
//
// One transaction is accepted per cycle while in_ready is high; its result
// passes the date register, then three weekday stages (divide by 100, day
// number sum, remainder by 7).
// Reset puts the date at January 1 of YEAR_MIN and empties the pipeline.
// Every stage moves on when the stage after it is empty or moving, so a
// stalled result stops only the stages behind it that are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter_weekday #(
	parameter int YEAR_MIN = 1000,
	parameter int YEAR_MAX = 9999
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire logic [cdcw_pkg::DAY_W-1:0]    load_day,
	input  wire logic [cdcw_pkg::MONTH_W-1:0]  load_month,
	input  wire logic [cdcw_pkg::YEAR_W-1:0]   load_year,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cdcw_pkg::DAY_W-1:0]         cur_day,
	output logic [cdcw_pkg::MONTH_W-1:0]       cur_month,
	output logic [cdcw_pkg::YEAR_W-1:0]        cur_year,
	output logic [cdcw_pkg::WDAY_W-1:0]        weekday,
	output logic [1:0]                         status
);
	import cdcw_pkg::*;

	logic    valid_s1;
	logic    ready_s2;
	date_t   date_s1;
	status_t status_s1;

	// Date register and operation logic.
	cdcw_date_step #(
		.YEAR_MIN (YEAR_MIN),
		.YEAR_MAX (YEAR_MAX)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.load_day   (load_day),
		.load_month (load_month),
		.load_year  (load_year),
		.ready_s2   (ready_s2),
		.valid_s1   (valid_s1),
		.date_s1    (date_s1),
		.status_s1  (status_s1)
	);

	// Weekday pipeline and output register.
	cdcw_weekday u_wday (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ready_s2  (ready_s2),
		.date_s1   (date_s1),
		.status_s1 (status_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year),
		.weekday   (weekday),
		.status    (status)
	);

`ifndef ASSERT_OFF
	// With no result pending the whole pipeline can move, so input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result is pending");

	// A range limit can only be reported on the first or last day of a year.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_LIMIT) |->
		((cur_day == 5'd31 && cur_month == 4'd12) ||
		 (cur_day == 5'd1 && cur_month == 4'd1)))
		else $error("range limit reported away from a year boundary");

	// Delivered dates and weekdays are always well formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_month >= 4'd1 && cur_month <= 4'd12 &&
		               cur_day >= 5'd1 && weekday != 3'd7))
		else $error("malformed date or weekday delivered");
`endif

endmodule

`default_nettype wire

// ===== rtl/cdcw_date_step.sv =====
// ----------------------------------------------------------------------------
// cdcw_date_step
// Holds the current date and applies one operation per accepted transaction:
// load with validation, step forward, step back, or query.
// ----------------------------------------------------------------------------
`default_nettype none

module cdcw_date_step #(
	parameter int YEAR_MIN = 1000,
	parameter int YEAR_MAX = 9999
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                operation,
	input  wire logic [cdcw_pkg::DAY_W-1:0]   load_day,
	input  wire logic [cdcw_pkg::MONTH_W-1:0] load_month,
	input  wire logic [cdcw_pkg::YEAR_W-1:0]  load_year,
	input  wire logic                      ready_s2,
	output logic                           valid_s1,
	output cdcw_pkg::date_t                date_s1,
	output cdcw_pkg::status_t              status_s1
);
	import cdcw_pkg::*;

	localparam logic [YEAR_W-1:0] YMIN = YEAR_W'(YEAR_MIN);
	localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);

	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;

	logic               accept;
	op_t                op;
	logic               leap_cur;
	logic               leap_load;
	logic [DAY_W-1:0]   len_cur;
	logic [DAY_W-1:0]   len_prev;
	logic [DAY_W-1:0]   len_load;
	logic               load_ok;
	date_t              nxt;
	status_t            st;

	// The stage is free when empty or when its transaction moves on.
	assign in_ready = !valid_s1 || ready_s2;
	assign accept   = in_valid && in_ready;

	// Next date and status for the operation at the input.
	always_comb begin
		op        = op_t'(operation);
		leap_cur  = is_leap(year_q);
		leap_load = is_leap(load_year);
		len_cur   = month_len(month_q, leap_cur);
		len_prev  = month_len(month_q - 4'd1, leap_cur);
		len_load  = month_len(load_month, leap_load);
		load_ok   = (load_year >= YMIN) && (load_year <= YMAX)
		            && (load_month >= 4'd1) && (load_month <= 4'd12)
		            && (load_day >= 5'd1) && (load_day <= len_load);

		nxt.day   = day_q;
		nxt.month = month_q;
		nxt.year  = year_q;
		st        = ST_OK;

		case (op)
			OP_LOAD: begin
				if (load_ok) begin
					nxt.day   = load_day;
					nxt.month = load_month;
					nxt.year  = load_year;
				end else begin
					st = ST_REJECT;
				end
			end
			OP_NEXT: begin
				if (year_q >= YMAX && month_q == 4'd12 && day_q == 5'd31) begin
					st = ST_LIMIT;
				end else if (day_q < len_cur) begin
					nxt.day = day_q + 5'd1;
				end else begin
					nxt.day = 5'd1;
					if (month_q >= 4'd12) begin
						nxt.month = 4'd1;
						nxt.year  = year_q + 14'd1;
					end else begin
						nxt.month = month_q + 4'd1;
					end
				end
			end
			OP_PREV: begin
				if (year_q <= YMIN && month_q == 4'd1 && day_q == 5'd1) begin
					st = ST_LIMIT;
				end else if (day_q > 5'd1) begin
					nxt.day = day_q - 5'd1;
				end else if (month_q <= 4'd1) begin
					// December always has 31 days, so the year change does not matter.
					nxt.month = 4'd12;
					nxt.year  = year_q - 14'd1;
					nxt.day   = 5'd31;
				end else begin
					nxt.month = month_q - 4'd1;
					nxt.day   = len_prev;
				end
			end
			OP_QUERY: begin
				st = ST_OK;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	// The date register doubles as the first pipeline stage's payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= YMIN;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				day_q    <= nxt.day;
				month_q  <= nxt.month;
				year_q   <= nxt.year;
				valid_s1 <= 1'b1;
			end else if (ready_s2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st;
		end
	end

	assign date_s1.day   = day_q;
	assign date_s1.month = month_q;
	assign date_s1.year  = year_q;

endmodule

`default_nettype wire

// ===== rtl/cdcw_weekday.sv =====
// ----------------------------------------------------------------------------
// cdcw_weekday
// Three-stage pipeline that derives the weekday of a date from its day
// number modulo 7 and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cdcw_weekday (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	output logic                               ready_s2,
	input  wire cdcw_pkg::date_t               date_s1,
	input  wire cdcw_pkg::status_t             status_s1,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cdcw_pkg::DAY_W-1:0]         cur_day,
	output logic [cdcw_pkg::MONTH_W-1:0]       cur_month,
	output logic [cdcw_pkg::YEAR_W-1:0]        cur_year,
	output logic [cdcw_pkg::WDAY_W-1:0]        weekday,
	output logic [1:0]                         status
);
	import cdcw_pkg::*;

	logic              valid_s2, valid_s3, valid_s4;
	logic              ready_s3, ready_s4;

	date_t             date_s2, date_s3, date_s4;
	status_t           status_s2, status_s3, status_s4;
	logic [YY_W-1:0]   yy_s2;
	logic [Q100_W-1:0] q100_s2;
	logic [WDAY_W-1:0] mofs_s2;
	logic [YY_W-1:0]   sum_s3;
	logic [WDAY_W-1:0] wday_s4;

	logic [YY_W-1:0]   yy_c;
	logic [YY_W-1:0]   sum_c;
	logic [31:0]       prod7_c;
	logic [Q7_W-1:0]   q7_c;
	logic [YY_W-1:0]   rem7_c;

	// Each stage advances when the next one is empty or moving.
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 2: March-based year and its quotient by 100.
	always_comb begin
		yy_c = YY_W'(date_s1.year) + YY_W'(JDN_YEAR_OFS)
		       - ((date_s1.month <= 4'd2) ? 15'd1 : 15'd0);
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			date_s2   <= date_s1;
			status_s2 <= status_s1;
			yy_s2     <= yy_c;
			q100_s2   <= div100(yy_c);
			mofs_s2   <= month_offset(date_s1.month);
		end
	end

	// Stage 3: day number reduced by 365 = 1 and -32045 = +1 (mod 7).
	always_comb begin
		sum_c = YY_W'(date_s2.day) + YY_W'(mofs_s2) + yy_s2 + (yy_s2 >> 2)
		        - YY_W'(q100_s2) + YY_W'(q100_s2 >> 2) + 15'd1;
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			date_s3   <= date_s2;
			status_s3 <= status_s2;
			sum_s3    <= sum_c;
		end
	end

	// Stage 4: remainder by 7 through the reciprocal.
	always_comb begin
		prod7_c = 32'(sum_s3) * 32'(RECIP7);
		q7_c    = prod7_c[RECIP7_SHIFT+Q7_W-1:RECIP7_SHIFT];
		rem7_c  = sum_s3 - YY_W'(YY_W'(q7_c) * YY_W'(7));
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			date_s4   <= date_s3;
			status_s4 <= status_s3;
			wday_s4   <= rem7_c[WDAY_W-1:0];
		end
	end

	assign out_valid = valid_s4;
	assign cur_day   = date_s4.day;
	assign cur_month = date_s4.month;
	assign cur_year  = date_s4.year;
	assign weekday   = wday_s4;
	assign status    = status_s4;

endmodule

`default_nettype wire

// ===== tb/sv/tb_calendar_date_counter_weekday.sv =====
// ----------------------------------------------------------------------------
// tb_calendar_date_counter_weekday
// Self-checking testbench for the Gregorian date counter with weekday output.
// A clocked driver feeds load, next-day, previous-day and query transactions
// from a queue. It starts with a directed set of calendar corner cases and
// then continues with random walks, range-limit runs and malformed loads.
// A calendar model predicts each result. A clocked monitor compares every
// result transaction field by field with the oldest prediction. Both sides
// insert random idle cycles. The receiver holds off once for a long stretch.
// The sender waits once until every outstanding result has returned.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_counter_weekday;

	timeunit 1ns;
	timeprecision 1ps;

	import cdcw_pkg::*;

	localparam int YEAR_LO      = 1000;
	localparam int YEAR_HI      = 9999;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_AT     = 500;
	localparam int LONG_HOLD_AT = 200;
	localparam int LONG_HOLD    = 80;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 10;

	// One input transaction as queued for the driver.
	typedef struct {
		op_t              op;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		bit               drain;
	} date_cmd_t;

	// One expected result transaction.
	typedef struct {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [WDAY_W-1:0]  wday;
		status_t          status;
	} date_result_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [1:0]           operation  = '0;
	logic [DAY_W-1:0]     load_day   = '0;
	logic [MONTH_W-1:0]   load_month = '0;
	logic [YEAR_W-1:0]    load_year  = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [DAY_W-1:0]     cur_day;
	logic [MONTH_W-1:0]   cur_month;
	logic [YEAR_W-1:0]    cur_year;
	logic [WDAY_W-1:0]    weekday;
	logic [1:0]           status;

	date_cmd_t    cmd_q[$];
	date_result_t date_expect_q[$];

	// Calendar state of the prediction.
	int cal_day   = 1;
	int cal_month = 1;
	int cal_year  = YEAR_LO;

	// Driver and monitor bookkeeping.
	date_cmd_t cur_cmd;
	logic      send_next;
	int        send_gap   = 0;
	bit        send_calm  = 1'b0;
	int        sent_now;
	int        sent_count = 0;
	logic      recv_next;
	int        recv_gap   = 0;
	bit        recv_calm  = 1'b0;
	bit        long_hold_done = 1'b0;
	int        results_seen = 0;
	int        idle_cycles  = 0;
	int        mismatches   = 0;

	calendar_date_counter_weekday #(
		.YEAR_MIN(YEAR_LO),
		.YEAR_MAX(YEAR_HI)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.load_day  (load_day),
		.load_month(load_month),
		.load_year (load_year),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year),
		.weekday   (weekday),
		.status    (status)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gregorian month length; zero for month codes outside 1..12.
	function automatic int days_in_month(input int m, input int y);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Weekday from the Julian day number; Monday is zero.
	function automatic int julian_weekday(input int d, input int m, input int y);
		int a;
		int yy;
		int mm;
		int jdn;
		a   = (m <= 2) ? 1 : 0;
		yy  = y + 4800 - a;
		mm  = m + 12 * a - 3;
		jdn = d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
		return jdn % 7;
	endfunction

	// Applies one transaction to the calendar state and queues its result.
	task automatic calendar_step(input date_cmd_t c);
		date_result_t r;
		int           d;
		int           m;
		int           y;
		r.status = ST_OK;
		d = int'(c.day);
		m = int'(c.month);
		y = int'(c.year);
		case (c.op)
			OP_LOAD: begin
				if (y >= YEAR_LO && y <= YEAR_HI && m >= 1 && m <= 12 &&
				    d >= 1 && d <= days_in_month(m, y)) begin
					cal_day   = d;
					cal_month = m;
					cal_year  = y;
				end else begin
					r.status = ST_REJECT;
				end
			end
			OP_NEXT: begin
				if (cal_year >= YEAR_HI && cal_month == 12 && cal_day == 31) begin
					r.status = ST_LIMIT;
				end else if (cal_day < days_in_month(cal_month, cal_year)) begin
					cal_day++;
				end else begin
					cal_day = 1;
					if (cal_month >= 12) begin
						cal_month = 1;
						cal_year++;
					end else begin
						cal_month++;
					end
				end
			end
			OP_PREV: begin
				if (cal_year <= YEAR_LO && cal_month == 1 && cal_day == 1) begin
					r.status = ST_LIMIT;
				end else if (cal_day > 1) begin
					cal_day--;
				end else begin
					if (cal_month <= 1) begin
						cal_month = 12;
						cal_year--;
					end else begin
						cal_month--;
					end
					cal_day = days_in_month(cal_month, cal_year);
				end
			end
			default: begin
			end
		endcase
		r.day   = cal_day[DAY_W-1:0];
		r.month = cal_month[MONTH_W-1:0];
		r.year  = cal_year[YEAR_W-1:0];
		r.wday  = WDAY_W'(julian_weekday(cal_day, cal_month, cal_year));
		date_expect_q.push_back(r);
	endtask

	task automatic push_cmd(input op_t op, input int d, input int m, input int y,
	                        input bit drain = 1'b0);
		date_cmd_t c;
		c.op    = op;
		c.day   = d[DAY_W-1:0];
		c.month = m[MONTH_W-1:0];
		c.year  = y[YEAR_W-1:0];
		c.drain = drain;
		cmd_q.push_back(c);
	endtask

	// A random valid date, biased toward the range ends and century leap rules.
	task automatic pick_valid_date(output int d, output int m, output int y);
		int special[9];
		special = '{YEAR_LO, YEAR_HI, 1600, 1900, 2000, 2100, 2400, 9996, 9900};
		if ($urandom_range(0, 9) < 7) begin
			y = $urandom_range(YEAR_LO, YEAR_HI);
		end else begin
			y = special[$urandom_range(0, 8)];
		end
		m = $urandom_range(1, 12);
		d = $urandom_range(1, days_in_month(m, y));
	endtask

	// Step operation for a walk; fwd_pct sets how often it goes forward.
	function automatic op_t walk_op(input int fwd_pct);
		int p;
		p = $urandom_range(0, 99);
		if (p < 8) begin
			return OP_QUERY;
		end else if (p < 8 + fwd_pct * 92 / 100) begin
			return OP_NEXT;
		end
		return OP_PREV;
	endfunction

	// Check one field of a result transaction.
	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
			mismatches++;
		end
	endtask

	// Driver: presents queued transactions, predicts each one on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			send_next = in_valid;
			sent_now  = sent_count;
			if (in_valid && in_ready) begin
				calendar_step(cur_cmd);
				sent_now  = sent_count + 1;
				send_next = 1'b0;
				if ($urandom_range(0, 39) == 0) begin
					send_calm = !send_calm;
				end
				send_gap = send_calm ? 0 : $urandom_range(0, 3);
			end
			if (!send_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_q.size() != 0 &&
				             (!cmd_q[0].drain || sent_now == results_seen)) begin
					cur_cmd    = cmd_q.pop_front();
					operation  <= cur_cmd.op;
					load_day   <= cur_cmd.day;
					load_month <= cur_cmd.month;
					load_year  <= cur_cmd.year;
					send_next  = 1'b1;
				end
			end
			sent_count <= sent_now;
			in_valid   <= send_next;
		end
	end

	// Monitor: checks each accepted result and paces out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (date_expect_q.size() == 0) begin
					$error("result transaction with no prediction pending");
					mismatches++;
				end else begin
					date_result_t e;
					e = date_expect_q.pop_front();
					check_field("cur_day", int'(e.day), int'(cur_day));
					check_field("cur_month", int'(e.month), int'(cur_month));
					check_field("cur_year", int'(e.year), int'(cur_year));
					check_field("weekday", int'(e.wday), int'(weekday));
					check_field("status", int'(e.status), int'(status));
				end
				// Hold off once for a long stretch so the pipeline backs up.
				if (!long_hold_done && results_seen == LONG_HOLD_AT) begin
					recv_gap = LONG_HOLD;
					long_hold_done = 1'b1;
				end else begin
					if ($urandom_range(0, 39) == 0) begin
						recv_calm = !recv_calm;
					end
					recv_gap = recv_calm ? 0 : $urandom_range(0, 3);
				end
				results_seen <= results_seen + 1;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				recv_next = 1'b0;
			end else begin
				recv_next = 1'b1;
			end
			out_ready <= recv_next;
		end
	end

	// Watchdog: counts cycles in which neither channel moves a transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int d;
		int m;
		int y;
		int pick;
		int len;
		int target;
		bit drain_placed;
		drain_placed = 1'b0;

		// Directed part: range limits, leap rules, rollovers, rejected loads.
		push_cmd(OP_QUERY, 0, 0, 0);
		push_cmd(OP_PREV, 0, 0, 0);
		push_cmd(OP_NEXT, 0, 0, 0);
		push_cmd(OP_PREV, 0, 0, 0);
		push_cmd(OP_LOAD, 31, 12, YEAR_HI);
		push_cmd(OP_NEXT, 0, 0, 0);
		push_cmd(OP_PREV, 31, 15, 16383);
		push_cmd(OP_LOAD, 1, 1, YEAR_LO - 1);
		push_cmd(OP_LOAD, 1, 1, YEAR_HI + 1);
		push_cmd(OP_LOAD, 31, 15, 16383);
		push_cmd(OP_LOAD, 0, 0, 0);
		push_cmd(OP_LOAD, 1, 13, 2000);
		push_cmd(OP_LOAD, 29, 2, 2000);
		push_cmd(OP_NEXT, 0, 0, 0);
		push_cmd(OP_PREV, 0, 0, 0);
		push_cmd(OP_LOAD, 29, 2, 1900);
		push_cmd(OP_LOAD, 29, 2, 2024);
		push_cmd(OP_LOAD, 29, 2, 2023);
		push_cmd(OP_LOAD, 31, 4, 2023);
		push_cmd(OP_LOAD, 31, 12, 2023);
		push_cmd(OP_NEXT, 0, 0, 0);
		push_cmd(OP_LOAD, 1, 3, 2100);
		push_cmd(OP_PREV, 0, 0, 0);
		push_cmd(OP_LOAD, 30, 2, 2024);
		push_cmd(OP_LOAD, 0, 5, 2024);

		// Random part: mostly loads followed by walks, plus malformed traffic.
		target = cmd_q.size() + RANDOM_ITEMS;
		while (cmd_q.size() < target) begin
			if (!drain_placed && cmd_q.size() >= DRAIN_AT) begin
				push_cmd(OP_QUERY, 0, 0, 0, 1'b1);
				drain_placed = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				pick_valid_date(d, m, y);
				push_cmd(OP_LOAD, d, m, y);
				repeat ($urandom_range(1, 12)) push_cmd(walk_op(50), d, m, y);
			end else if (pick < 60) begin
				// Walk into the upper end of the range.
				push_cmd(OP_LOAD, $urandom_range(24, 31), 12, YEAR_HI);
				repeat ($urandom_range(3, 10)) push_cmd(walk_op(80), 0, 0, 0);
			end else if (pick < 70) begin
				// Walk into the lower end of the range.
				push_cmd(OP_LOAD, $urandom_range(1, 8), 1, YEAR_LO);
				repeat ($urandom_range(3, 10)) push_cmd(walk_op(20), 0, 0, 0);
			end else if (pick < 85) begin
				// Start on a month boundary and cross it.
				pick_valid_date(d, m, y);
				d = $urandom_range(0, 1) ? days_in_month(m, y) : 1;
				push_cmd(OP_LOAD, d, m, y);
				repeat ($urandom_range(1, 4)) push_cmd(walk_op(50), 0, 0, 0);
			end else begin
				// Malformed loads and raw random transactions.
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1)) begin
						pick_valid_date(d, m, y);
						len = days_in_month(m, y);
						push_cmd(OP_LOAD, $urandom_range(0, 1) ? len + 1 : 0, m, y);
					end else begin
						push_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
						         $urandom_range(0, 15), $urandom_range(0, 16383));
					end
				end
			end
		end

		// Hold reset, then release it at a clock edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all transactions to be sent and all results to return.
		while (!(cmd_q.size() == 0 && !in_valid && sent_count == results_seen)) begin
			@(negedge clk);
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("timeout: no transaction for %0d cycles", idle_cycles);
				mismatches++;
				break;
			end
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (date_expect_q.size() != 0) begin
			$error("%0d predicted results never arrived", date_expect_q.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
